/* hdl/sensor_text_frame_encoder_assert.svh */
// assertion macros for the frame encoder checker
`ifndef SENSOR_TEXT_FRAME_ENCODER_ASSERT_SVH
`define SENSOR_TEXT_FRAME_ENCODER_ASSERT_SVH

// same-cycle implication, clocked on i_clk, quiet in reset
`define STFE_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication, clocked on i_clk, quiet in reset
`define STFE_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

/* hdl/stfe_pkg.sv */
`timescale 1ns / 1ps
package stfe_pkg;

    localparam int TEMP_W  = 32;
    localparam int BYTE_W  = 8;
    localparam int FRAME_W = 64;
    localparam int IN_W    = 40;

    localparam logic [7:0] SYNC_BYTE   = 8'hFF;
    localparam logic [7:0] CMD_SENSOR  = 8'h10;
    localparam logic [7:0] CMD_MESSAGE = 8'h20;
    localparam logic [7:0] TERMINATOR  = 8'h00;
    localparam logic [7:0] PARAM_NONE  = 8'h00;

    localparam logic KIND_TEMP = 1'b0;
    localparam logic KIND_TEXT = 1'b1;

    localparam logic [1:0] FILL_LAST = 2'd3;

    typedef struct packed {
        logic              kind;
        logic [TEMP_W-1:0] temp_value;
        logic [BYTE_W-1:0] text_byte;
    } t_item;

    typedef struct packed {
        logic              emit;
        logic [7:0]        cmd;
        logic [7:0]        param;
        logic [TEMP_W-1:0] payload;
    } t_frame_req;

endpackage

/* hdl/stfe_text_packer.sv */
`timescale 1ns / 1ps
module stfe_text_packer (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_fire,
    input  stfe_pkg::t_item    i_item,
    output stfe_pkg::t_frame_req o_req
);
    import stfe_pkg::*;

    logic [TEMP_W-1:0] r_packed, n_packed;
    logic [1:0]        r_fill,   n_fill;
    logic [7:0]        r_seq,    n_seq;
    logic [TEMP_W-1:0] w_merged;
    logic              w_ended;
    logic              w_full;

    always_comb begin
        w_merged = r_packed;
        case (r_fill)
            2'd0: w_merged[31:24] = i_item.text_byte;
            2'd1: w_merged[23:16] = i_item.text_byte;
            2'd2: w_merged[15:8]  = i_item.text_byte;
            2'd3: w_merged[7:0]   = i_item.text_byte;
            default: w_merged = r_packed;
        endcase
    end

    assign w_ended = (i_item.text_byte == TERMINATOR);
    assign w_full  = (r_fill == FILL_LAST);

    always_comb begin
        n_packed      = r_packed;
        n_fill        = r_fill;
        n_seq         = r_seq;
        o_req.emit    = 1'b0;
        o_req.cmd     = CMD_MESSAGE;
        o_req.param   = r_seq;
        o_req.payload = w_merged;
        if (i_item.kind == KIND_TEMP) begin
            o_req.emit    = 1'b1;
            o_req.cmd     = CMD_SENSOR;
            o_req.param   = PARAM_NONE;
            o_req.payload = i_item.temp_value;
        end else if (w_full || w_ended) begin
            o_req.emit = 1'b1;
            if (i_fire) begin
                n_packed = '0;
                n_fill   = '0;
                n_seq    = w_ended ? 8'd0 : r_seq + 8'd1;
            end
        end else if (i_fire) begin
            n_packed = w_merged;
            n_fill   = r_fill + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_packed <= '0;
            r_fill   <= '0;
            r_seq    <= '0;
        end else begin
            r_packed <= n_packed;
            r_fill   <= n_fill;
            r_seq    <= n_seq;
        end
    end

endmodule

/* hdl/stfe_frame_builder.sv */
`timescale 1ns / 1ps
module stfe_frame_builder (
    input  stfe_pkg::t_frame_req        i_req,
    output logic [stfe_pkg::FRAME_W-1:0] o_frame
);
    import stfe_pkg::*;

    logic [7:0] w_sum;

    // checksum over the seven leading bytes, modulo 256
    assign w_sum = SYNC_BYTE + i_req.cmd + i_req.param
                 + i_req.payload[31:24] + i_req.payload[23:16]
                 + i_req.payload[15:8]  + i_req.payload[7:0];

    assign o_frame = {SYNC_BYTE, i_req.cmd, i_req.param, i_req.payload, w_sum};

endmodule

/* hdl/sensor_text_frame_encoder.sv */
`timescale 1ns / 1ps
// Frame encoder: takes one word per cycle (tuser 0 = 32-bit temperature, tuser 1 = one text
// byte) and gives 64-bit frames FF, command, parameter, four payload bytes, checksum. A
// temperature word gives a frame with command 10h; text bytes are packed first byte highest
// and give a command 20h frame with the sequence number after four bytes or at a zero byte.
// Each word passes an input register and then a result register, which holds its frame on
// the output, and a new word can be taken every cycle while the output is not stalled.
module sensor_text_frame_encoder (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,  // temp_value [31:0], text_byte [39:32]
    input  logic [0:0]  s_axis_tuser,  // kind [0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [63:0] m_axis_tdata   // frame [63:0]
);
    import stfe_pkg::*;

    logic                 r_in_valid;
    t_item                r_in_item;
    logic                 r_out_valid;
    logic [FRAME_W-1:0]   r_out_frame;
    logic                 w_adv;
    logic                 w_fire;
    t_frame_req           w_req;
    logic [FRAME_W-1:0]   w_frame;

    assign w_adv         = !r_out_valid || m_axis_tready;
    assign w_fire        = r_in_valid && w_adv;
    assign s_axis_tready = !r_in_valid || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tvalid && s_axis_tready) begin
            r_in_valid <= 1'b1;
        end else if (w_adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_item.kind       <= s_axis_tuser[0];
            r_in_item.temp_value <= s_axis_tdata[31:0];
            r_in_item.text_byte  <= s_axis_tdata[39:32];
        end
    end

    stfe_text_packer u_packer (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (w_fire),
        .i_item  (r_in_item),
        .o_req   (w_req)
    );

    stfe_frame_builder u_builder (
        .i_req   (w_req),
        .o_frame (w_frame)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= w_fire && w_req.emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire && w_req.emit) begin
            r_out_frame <= w_frame;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_frame;

endmodule

/* hdl/stfe_checker.sv */
`timescale 1ns / 1ps
`include "sensor_text_frame_encoder_assert.svh"
module stfe_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [39:0] s_axis_tdata,
    input logic [0:0]  s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [63:0] m_axis_tdata
);
    import stfe_pkg::*;

    logic [7:0] w_sum;
    logic [7:0] w_cmd;
    logic       w_stall;
    logic       w_temp_frame;
    logic       w_param_none;
    logic       w_in_seen;

    assign w_sum = m_axis_tdata[63:56] + m_axis_tdata[55:48] + m_axis_tdata[47:40]
                 + m_axis_tdata[39:32] + m_axis_tdata[31:24] + m_axis_tdata[23:16]
                 + m_axis_tdata[15:8];
    assign w_cmd        = m_axis_tdata[55:48];
    assign w_stall      = m_axis_tvalid && !m_axis_tready;
    assign w_temp_frame = m_axis_tvalid && (w_cmd == CMD_SENSOR);
    assign w_param_none = (m_axis_tdata[47:40] == PARAM_NONE);
    assign w_in_seen    = s_axis_tvalid && s_axis_tready
                       && (s_axis_tdata != '0 || s_axis_tuser != '0);

    `STFE_ASSERT_NEXT(a_out_hold, w_stall, m_axis_tvalid && $stable(m_axis_tdata), "stalled frame changed")
    `STFE_ASSERT_NOW(a_sync, m_axis_tvalid, m_axis_tdata[63:56] == SYNC_BYTE, "bad sync byte")
    `STFE_ASSERT_NOW(a_checksum, m_axis_tvalid, m_axis_tdata[7:0] == w_sum, "bad checksum")
    `STFE_ASSERT_NOW(a_cmd, m_axis_tvalid, w_cmd == CMD_SENSOR || w_cmd == CMD_MESSAGE, "bad command")
    `STFE_ASSERT_NOW(a_temp_param, w_temp_frame, w_param_none || w_in_seen, "temperature parameter")

endmodule

bind sensor_text_frame_encoder stfe_checker u_stfe_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

/* sim/sensor_text_frame_encoder_checker.sv */
`timescale 1ns / 1ps
module sensor_text_frame_encoder_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    input  logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // temp_value [31:0], text_byte [39:32]
    input  logic [0:0]  s_axis_tuser,   // kind [0]
    input  logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic [63:0] m_axis_tdata,   // frame [63:0]
    output int          o_fail_count,
    output int          o_pending_count
);
    import stfe_pkg::*;

    logic [FRAME_W-1:0] frames_due[$];
    logic [TEMP_W-1:0]  text_word = '0;
    logic [1:0]         text_fill = '0;
    logic [7:0]         text_seq  = '0;
    int                 fails     = 0;

    function automatic logic [FRAME_W-1:0] frame_of(input logic [7:0] cmd,
                                                    input logic [7:0] param,
                                                    input logic [TEMP_W-1:0] payload);
        logic [7:0] sum;
        sum = SYNC_BYTE + cmd + param + payload[31:24] + payload[23:16]
            + payload[15:8] + payload[7:0];
        return {SYNC_BYTE, cmd, param, payload, sum};
    endfunction

    always @(posedge i_clk) begin
        logic [TEMP_W-1:0]  word_now;
        logic [7:0]         ch;
        logic [FRAME_W-1:0] want;
        if (!i_rst_n) begin
            text_word <= '0;
            text_fill <= '0;
            text_seq  <= '0;
            frames_due.delete();
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                if (s_axis_tuser[0] == KIND_TEMP) begin
                    frames_due.push_back(frame_of(CMD_SENSOR, PARAM_NONE, s_axis_tdata[31:0]));
                end else begin
                    ch       = s_axis_tdata[39:32];
                    word_now = text_word | ({24'd0, ch} << (24 - 8 * int'(text_fill)));
                    if (ch == TERMINATOR || text_fill == FILL_LAST) begin
                        frames_due.push_back(frame_of(CMD_MESSAGE, text_seq, word_now));
                        text_word <= '0;
                        text_fill <= '0;
                        text_seq  <= (ch == TERMINATOR) ? 8'd0 : text_seq + 8'd1;
                    end else begin
                        text_word <= word_now;
                        text_fill <= text_fill + 2'd1;
                    end
                end
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (frames_due.size() == 0) begin
                    $display("%0t: unexpected frame, expected none, got %h",
                             $time, m_axis_tdata);
                    fails++;
                end else begin
                    want = frames_due.pop_front();
                    if (m_axis_tdata !== want) begin
                        $display("%0t: frame mismatch, expected %h, got %h",
                                 $time, want, m_axis_tdata);
                        fails++;
                    end
                end
            end
        end
        o_pending_count = frames_due.size();
        o_fail_count    = fails;
    end

endmodule

/* sim/sensor_text_frame_encoder_tb.sv */
`timescale 1ns / 1ps
module sensor_text_frame_encoder_tb;
    import stfe_pkg::*;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [39:0] s_axis_tdata  = '0;   // temp_value [31:0], text_byte [39:32]
    logic [0:0]  s_axis_tuser  = '0;   // kind [0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;         // frame [63:0]

    int fail_count;
    int pending_count;
    bit calm = 1'b0;

    sensor_text_frame_encoder i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    sensor_text_frame_encoder_checker i_checker (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .s_axis_tvalid   (s_axis_tvalid),
        .s_axis_tready   (s_axis_tready),
        .s_axis_tdata    (s_axis_tdata),
        .s_axis_tuser    (s_axis_tuser),
        .m_axis_tvalid   (m_axis_tvalid),
        .m_axis_tready   (m_axis_tready),
        .m_axis_tdata    (m_axis_tdata),
        .o_fail_count    (fail_count),
        .o_pending_count (pending_count)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    always @(negedge i_clk) begin
        m_axis_tready <= calm || ($urandom_range(99) >= 7);
    end

    initial begin
        #2_000_000;
        $display("CHECK FAILED");
        $finish;
    end

    // called at a falling edge, returns at the falling edge after the word is taken
    task automatic offer_item(input logic kind, input logic [31:0] temp,
                              input logic [7:0] ch);
        while (!calm && $urandom_range(99) < 7) begin
            s_axis_tvalid = 1'b0;
            @(negedge i_clk);
        end
        s_axis_tvalid   = 1'b1;
        s_axis_tuser[0] = kind;
        s_axis_tdata    = {ch, temp};
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
    endtask

    initial begin
        int sent;
        int text_sent;
        int len;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        offer_item(KIND_TEMP, 32'h0000_0000, 8'h00);
        offer_item(KIND_TEMP, 32'hFFFF_FFFF, 8'hFF);
        offer_item(KIND_TEMP, 32'h1234_5678, 8'h5A);
        offer_item(KIND_TEMP, 32'h0000_FF01, 8'hA5);
        // full word, then a bare terminator with the bumped sequence
        offer_item(KIND_TEXT, 32'hFFFF_FFFF, 8'h41);
        offer_item(KIND_TEXT, 32'h0000_0000, 8'h42);
        offer_item(KIND_TEXT, 32'hA5A5_A5A5, 8'h43);
        offer_item(KIND_TEXT, 32'h5A5A_5A5A, 8'h44);
        offer_item(KIND_TEXT, 32'hFFFF_FFFF, TERMINATOR);
        offer_item(KIND_TEXT, 32'h0000_0000, 8'hFF);
        offer_item(KIND_TEXT, 32'h0000_0000, 8'hFF);
        offer_item(KIND_TEXT, 32'h0000_0000, 8'hFF);
        offer_item(KIND_TEXT, 32'h0000_0000, 8'hFF);
        // temperature in the middle of a message, short message
        offer_item(KIND_TEXT, 32'h0000_0000, 8'h61);
        offer_item(KIND_TEMP, 32'h8000_0000, 8'h00);
        offer_item(KIND_TEXT, 32'h0000_0000, 8'h62);
        offer_item(KIND_TEXT, 32'h0000_0000, TERMINATOR);
        // terminator in the last slot
        offer_item(KIND_TEXT, 32'h0000_0000, 8'h01);
        offer_item(KIND_TEXT, 32'h0000_0000, 8'h80);
        offer_item(KIND_TEXT, 32'h0000_0000, 8'h7F);
        offer_item(KIND_TEXT, 32'h0000_0000, TERMINATOR);

        // long message so the sequence number wraps
        sent      = 0;
        text_sent = 0;
        while (text_sent < 1030) begin
            calm = (sent < 300);
            if ($urandom_range(99) < 10) begin
                offer_item(KIND_TEMP, $urandom, 8'($urandom_range(255)));
            end else begin
                offer_item(KIND_TEXT, $urandom, 8'($urandom_range(1, 255)));
                text_sent++;
            end
            sent++;
        end
        calm = 1'b0;
        offer_item(KIND_TEXT, $urandom, TERMINATOR);
        sent++;

        while (sent < 1580) begin
            len = $urandom_range(0, 11);
            for (int j = 0; j < len; j++) begin
                if ($urandom_range(99) < 15) begin
                    offer_item(KIND_TEMP, $urandom, 8'($urandom_range(255)));
                end else begin
                    offer_item(KIND_TEXT, $urandom, 8'($urandom_range(1, 255)));
                end
                sent++;
            end
            if ($urandom_range(99) < 85) begin
                offer_item(KIND_TEXT, $urandom, TERMINATOR);
                sent++;
            end
        end
        s_axis_tvalid = 1'b0;

        while (pending_count != 0) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
        if (fail_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

/* sensor_text_frame_encoder.f */
+incdir+hdl
hdl/stfe_pkg.sv
hdl/stfe_text_packer.sv
hdl/stfe_frame_builder.sv
hdl/sensor_text_frame_encoder.sv
hdl/stfe_checker.sv
sim/sensor_text_frame_encoder_checker.sv
sim/sensor_text_frame_encoder_tb.sv
